/* sv/ims_pkg.sv */
// Shared constants and control types for the IMU magnitude statistics block.
package ims_pkg;

  localparam int unsigned MAX_SAMPLES = 1048576;
  localparam int unsigned CNT_W       = 21;
  localparam int unsigned TOT_W       = 36;
  localparam int unsigned MAG_W       = 16;
  localparam int unsigned CFG_IDX_W   = 8;

  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_SAMPLES);

  localparam logic [CFG_IDX_W-1:0] REG_ACCEL_LIMIT = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_RATE_LIMIT  = CFG_IDX_W'(1);

  localparam logic [MAG_W-1:0] ACCEL_LIMIT_RST = 16'd7680;
  localparam logic [MAG_W-1:0] RATE_LIMIT_RST  = 16'd14336;

  // Lane numbers of the two vectors inside the datapath.
  localparam logic LANE_ACCEL = 1'b0;
  localparam logic LANE_RATE  = 1'b1;

  typedef struct packed {
    logic       load;
    logic       sq_mul;
    logic       sq_add;
    logic [1:0] axis;
    logic       root_init;
    logic       root_step;
    logic       upd;
    logic       div_init;
    logic       div_step;
    logic       out_load;
    logic       clear;
  } ims_cmd_t;

  typedef struct packed {
    logic last;
    logic count_zero;
  } ims_status_t;

endpackage

/* sv/ims_ctrl.sv */
// Sequencer for squaring, square root, statistics update, mean division and output.
module ims_ctrl
  import ims_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic        out_tready,
  output logic        out_tvalid,
  input  ims_status_t status,
  output ims_cmd_t    cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SQ    = 3'd1;
  localparam logic [2:0] S_RINIT = 3'd2;
  localparam logic [2:0] S_ROOT  = 3'd3;
  localparam logic [2:0] S_UPD   = 3'd4;
  localparam logic [2:0] S_DINIT = 3'd5;
  localparam logic [2:0] S_DIV   = 3'd6;
  localparam logic [2:0] S_DONE  = 3'd7;

  localparam logic [3:0] SQ_LAST   = 4'd3;
  localparam logic [3:0] STEP_LAST = 4'd15;

  logic [2:0] state_r, state_nxt;
  logic [3:0] cnt_r, cnt_nxt;
  logic       out_valid_r, out_valid_nxt;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          cnt_nxt   = '0;
          state_nxt = S_SQ;
        end
      end
      S_SQ: begin
        // Multiplier result of one axis is registered and added to the sum in the next cycle.
        cmd.axis   = cnt_r[1:0];
        cmd.sq_mul = (cnt_r != SQ_LAST);
        cmd.sq_add = (cnt_r != 4'd0);
        if (cnt_r == SQ_LAST) begin
          state_nxt = S_RINIT;
        end else begin
          cnt_nxt = cnt_r + 4'd1;
        end
      end
      S_RINIT: begin
        cmd.root_init = 1'b1;
        cnt_nxt       = '0;
        state_nxt     = S_ROOT;
      end
      S_ROOT: begin
        cmd.root_step = 1'b1;
        if (cnt_r == STEP_LAST) begin
          state_nxt = S_UPD;
        end else begin
          cnt_nxt = cnt_r + 4'd1;
        end
      end
      S_UPD: begin
        cmd.upd   = 1'b1;
        state_nxt = status.last ? S_DINIT : S_DONE;
      end
      S_DINIT: begin
        cmd.div_init = 1'b1;
        cnt_nxt      = '0;
        state_nxt    = status.count_zero ? S_DONE : S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (cnt_r == STEP_LAST) begin
          state_nxt = S_DONE;
        end else begin
          cnt_nxt = cnt_r + 4'd1;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          cmd.out_load  = 1'b1;
          cmd.clear     = status.last;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

/* sv/ims_datapath.sv */
// Two-lane datapath: squarers, bit-pair square roots, batch statistics and mean dividers.
module ims_datapath
  import ims_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  ims_cmd_t             cmd,
  input  logic [127:0]         in_tdata,
  input  logic                 in_tlast,
  input  logic                 cfg_valid,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]          cfg_data,
  output ims_status_t          status,
  output logic [159:0]         out_tdata,
  output logic                 out_tlast,
  output logic [1:0]           out_tuser
);

  logic [15:0] accel_limit_r, rate_limit_r;

  logic [127:0] smp_r;
  logic         last_r;

  logic [1:0][31:0]      sq_r, sum_r, rad_r;
  logic [1:0][16:0]      rem_r;
  logic [1:0][MAG_W-1:0] root_r;
  logic                  acc_r;

  logic [CNT_W-1:0]      count_r;
  logic [1:0][MAG_W-1:0] low_r, high_r;
  logic [1:0][TOT_W-1:0] total_r;

  logic [1:0][20:0]      drem_r;
  logic [1:0][MAG_W-1:0] quo_r;

  logic [159:0] out_data_r;
  logic         out_last_r;
  logic [1:0]   out_user_r;

  logic [1:0][15:0]      axis_abs;
  logic [1:0][16:0]      rem_nxt;
  logic [1:0][MAG_W-1:0] root_nxt;
  logic [1:0][20:0]      drem_nxt;
  logic [1:0][MAG_W-1:0] quo_nxt;
  logic                  acc_w;
  logic                  stats_on;

  // Pick the axis being squared and take its absolute value.
  always_comb begin
    logic signed [15:0] v;
    for (int l = 0; l < 2; l++) begin
      case (cmd.axis)
        2'd0:    v = smp_r[32 + 48*l +: 16];
        2'd1:    v = smp_r[48 + 48*l +: 16];
        default: v = smp_r[64 + 48*l +: 16];
      endcase
      axis_abs[l] = v[15] ? 16'(-v) : 16'(v);
    end
  end

  // One result bit of each square root per step.
  always_comb begin
    logic [18:0] rt, trial;
    for (int l = 0; l < 2; l++) begin
      rt    = {rem_r[l], rad_r[l][31:30]};
      trial = {1'b0, root_r[l], 2'b01};
      if (rt >= trial) begin
        rem_nxt[l]  = 17'(rt - trial);
        root_nxt[l] = {root_r[l][MAG_W-2:0], 1'b1};
      end else begin
        rem_nxt[l]  = rt[16:0];
        root_nxt[l] = {root_r[l][MAG_W-2:0], 1'b0};
      end
    end
  end

  // One quotient bit of each mean per step; the quotient is known to fit 16 bits.
  always_comb begin
    logic [21:0] ds;
    logic        ge;
    for (int l = 0; l < 2; l++) begin
      ds = {drem_r[l], quo_r[l][MAG_W-1]};
      ge = (ds >= {1'b0, count_r});
      drem_nxt[l] = ge ? 21'(ds - {1'b0, count_r}) : ds[20:0];
      quo_nxt[l]  = {quo_r[l][MAG_W-2:0], ge};
    end
  end

  assign acc_w = (root_r[LANE_ACCEL] < accel_limit_r) && (root_r[LANE_RATE] < rate_limit_r);
  assign status.last       = last_r;
  assign status.count_zero = (count_r == '0);
  assign stats_on          = last_r && (count_r != '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      accel_limit_r <= ACCEL_LIMIT_RST;
      rate_limit_r  <= RATE_LIMIT_RST;
    end else if (cfg_valid) begin
      if (cfg_index == REG_ACCEL_LIMIT) begin
        accel_limit_r <= cfg_data;
      end else if (cfg_index == REG_RATE_LIMIT) begin
        rate_limit_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      smp_r  <= in_tdata;
      last_r <= in_tlast;
    end
    for (int l = 0; l < 2; l++) begin
      if (cmd.sq_mul) begin
        sq_r[l] <= 32'(axis_abs[l]) * 32'(axis_abs[l]);
      end
      if (cmd.load) begin
        sum_r[l] <= '0;
      end else if (cmd.sq_add) begin
        sum_r[l] <= sum_r[l] + sq_r[l];
      end
      if (cmd.root_init) begin
        rad_r[l]  <= sum_r[l];
        rem_r[l]  <= '0;
        root_r[l] <= '0;
      end else if (cmd.root_step) begin
        rad_r[l]  <= {rad_r[l][29:0], 2'b00};
        rem_r[l]  <= rem_nxt[l];
        root_r[l] <= root_nxt[l];
      end
      if (cmd.div_init) begin
        drem_r[l] <= 21'(total_r[l][TOT_W-1:MAG_W]);
        quo_r[l]  <= total_r[l][MAG_W-1:0];
      end else if (cmd.div_step) begin
        drem_r[l] <= drem_nxt[l];
        quo_r[l]  <= quo_nxt[l];
      end
    end
    if (cmd.upd) begin
      acc_r <= acc_w;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clear) begin
      count_r <= '0;
      low_r   <= '0;
      high_r  <= '0;
      total_r <= '0;
    end else if (cmd.upd && acc_w && (count_r < MAX_CNT)) begin
      for (int l = 0; l < 2; l++) begin
        if (count_r == '0 || root_r[l] < low_r[l]) begin
          low_r[l] <= root_r[l];
        end
        if (count_r == '0 || root_r[l] > high_r[l]) begin
          high_r[l] <= root_r[l];
        end
        total_r[l] <= total_r[l] + TOT_W'(root_r[l]);
      end
      count_r <= count_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data_r[31:0]    <= smp_r[31:0];
      out_data_r[47:32]   <= root_r[LANE_ACCEL];
      out_data_r[63:48]   <= root_r[LANE_RATE];
      out_data_r[79:64]   <= stats_on ? low_r[LANE_ACCEL]  : '0;
      out_data_r[95:80]   <= stats_on ? high_r[LANE_ACCEL] : '0;
      out_data_r[111:96]  <= stats_on ? quo_r[LANE_ACCEL]  : '0;
      out_data_r[127:112] <= stats_on ? low_r[LANE_RATE]   : '0;
      out_data_r[143:128] <= stats_on ? high_r[LANE_RATE]  : '0;
      out_data_r[159:144] <= stats_on ? quo_r[LANE_RATE]   : '0;
      out_last_r          <= last_r;
      out_user_r          <= {last_r && (count_r == '0), acc_r};
    end
  end

  assign out_tdata = out_data_r;
  assign out_tlast = out_last_r;
  assign out_tuser = out_user_r;

endmodule

/* sv/imu_magnitude_statistics.sv */
// Top level of the IMU magnitude statistics block.
// Each input beat is one IMU sample; each gives one output beat with the floor
// square root magnitudes of the acceleration and angular rate vectors and an
// accepted flag (both magnitudes strictly below their limit registers). Accepted
// samples feed a running min, max and sum; on the beat marked tlast the output
// also carries min, max and truncated mean, or the no-samples flag, and the
// batch is cleared. A sample passes from acceptance to its output beat through
// squaring and summing on one multiplier per vector, then a 16-step bit-pair
// square root. The last beat of a batch also runs the 16-step mean divider,
// which is skipped if the batch is empty. A new sample is taken as soon as the
// previous one has been placed in the output register; if that register is
// still held by a stalled consumer, the block waits for it.
module imu_magnitude_statistics
  import ims_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  // timestamp, accel_x, accel_y, accel_z, rate_x, rate_y, rate_z
  input  logic [127:0]         in_tdata,
  input  logic                 in_tlast,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  // time_out, accel_magnitude, rate_magnitude, accel_min, accel_max, accel_mean,
  // rate_min, rate_max, rate_mean
  output logic [159:0]         out_tdata,
  output logic                 out_tlast,
  // accepted, no_samples
  output logic [1:0]           out_tuser,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]          cfg_data
);

  ims_cmd_t    cmd;
  ims_status_t status;

  assign cfg_ready = 1'b1;

  ims_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .out_tready(out_tready),
    .out_tvalid(out_tvalid),
    .status    (status),
    .cmd       (cmd)
  );

  ims_datapath u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_tdata (in_tdata),
    .in_tlast (in_tlast),
    .cfg_valid(cfg_valid),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .status   (status),
    .out_tdata(out_tdata),
    .out_tlast(out_tlast),
    .out_tuser(out_tuser)
  );

  // A sample is worked on in the sequencer states after idle, so the input closes right after a beat.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input still ready right after an accepted beat");

  a_stats_zero_mid_batch: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> (out_tdata[159:64] == '0) && !out_tuser[1])
    else $error("statistics present on a beat that does not end a batch");

  a_empty_batch_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1] |-> out_tlast && !out_tuser[0] && (out_tdata[159:64] == '0))
    else $error("empty batch report carries statistics or an accepted sample");

endmodule

/* sim/imu_magnitude_statistics_tb.sv */
// Self-checking testbench for the IMU magnitude statistics block.
module imu_magnitude_statistics_tb;
  import ims_pkg::*;

  localparam int IDLE_PERCENT   = 23;
  localparam int STALL_CYCLES   = 400;
  localparam int WATCHDOG_LIMIT = 4000;

  typedef struct packed {
    logic        last;
    logic [15:0] rate_z;
    logic [15:0] rate_y;
    logic [15:0] rate_x;
    logic [15:0] accel_z;
    logic [15:0] accel_y;
    logic [15:0] accel_x;
    logic [31:0] stamp;
  } imu_sample_t;

  typedef struct packed {
    logic [31:0] time_out;
    logic        accepted;
    logic [15:0] accel_mag;
    logic [15:0] rate_mag;
    logic        stats_ready;
    logic        no_samples;
    logic [15:0] accel_min;
    logic [15:0] accel_max;
    logic [15:0] accel_mean;
    logic [15:0] rate_min;
    logic [15:0] rate_max;
    logic [15:0] rate_mean;
  } imu_result_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_tvalid = 1'b0;
  logic                 in_tready;
  // timestamp, accel_x, accel_y, accel_z, rate_x, rate_y, rate_z
  logic [127:0]         in_tdata = '0;
  logic                 in_tlast = 1'b0;
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  // time_out, accel_magnitude, rate_magnitude, accel_min, accel_max, accel_mean,
  // rate_min, rate_max, rate_mean
  logic [159:0]         out_tdata;
  logic                 out_tlast;
  // accepted, no_samples
  logic [1:0]           out_tuser;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [15:0]          cfg_data = '0;

  logic steady = 1'b0;
  logic sink_hold = 1'b0;
  int   err_count = 0;
  int   stall_cycles = 0;

  imu_result_t results_due [$];

  // Predictor copy of the limit registers and the batch statistics.
  logic [15:0]      lim_accel = ACCEL_LIMIT_RST;
  logic [15:0]      lim_rate = RATE_LIMIT_RST;
  logic [CNT_W-1:0] batch_count = '0;
  logic [15:0]      accel_lo = '0;
  logic [15:0]      accel_hi = '0;
  logic [15:0]      rate_lo = '0;
  logic [15:0]      rate_hi = '0;
  logic [TOT_W-1:0] accel_sum = '0;
  logic [TOT_W-1:0] rate_sum = '0;

  imu_magnitude_statistics dut (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic logic [15:0] floor_root(input logic [31:0] n);
    logic [15:0] root;
    logic [15:0] trial;
    logic [31:0] square;
    root = '0;
    for (int b = 15; b >= 0; b--) begin
      trial = root | (16'd1 << b);
      square = 32'(trial) * 32'(trial);
      if (square <= n) root = trial;
    end
    return root;
  endfunction

  function automatic logic [15:0] vector_norm(input logic [15:0] x, y, z);
    logic [31:0] acc;
    int          c;
    c = int'($signed(x));
    acc = 32'(c * c);
    c = int'($signed(y));
    acc += 32'(c * c);
    c = int'($signed(z));
    acc += 32'(c * c);
    return floor_root(acc);
  endfunction

  task automatic predict_result(input imu_sample_t s, output imu_result_t r);
    logic [15:0] am;
    logic [15:0] rm;
    logic        ok;
    am = vector_norm(s.accel_x, s.accel_y, s.accel_z);
    rm = vector_norm(s.rate_x, s.rate_y, s.rate_z);
    ok = (am < lim_accel) && (rm < lim_rate);
    // A full batch still flags the sample as accepted but freezes the statistics.
    if (ok && batch_count < MAX_CNT) begin
      if (batch_count == 0) begin
        accel_lo = am;
        accel_hi = am;
        rate_lo = rm;
        rate_hi = rm;
      end else begin
        if (am < accel_lo) accel_lo = am;
        if (am > accel_hi) accel_hi = am;
        if (rm < rate_lo) rate_lo = rm;
        if (rm > rate_hi) rate_hi = rm;
      end
      accel_sum += TOT_W'(am);
      rate_sum += TOT_W'(rm);
      batch_count++;
    end
    r = '0;
    r.time_out = s.stamp;
    r.accepted = ok;
    r.accel_mag = am;
    r.rate_mag = rm;
    if (s.last) begin
      r.stats_ready = 1'b1;
      if (batch_count == 0) begin
        r.no_samples = 1'b1;
      end else begin
        r.accel_min = accel_lo;
        r.accel_max = accel_hi;
        r.accel_mean = 16'(accel_sum / TOT_W'(batch_count));
        r.rate_min = rate_lo;
        r.rate_max = rate_hi;
        r.rate_mean = 16'(rate_sum / TOT_W'(batch_count));
      end
      batch_count = '0;
      accel_lo = '0;
      accel_hi = '0;
      rate_lo = '0;
      rate_hi = '0;
      accel_sum = '0;
      rate_sum = '0;
    end
  endtask

  task automatic send_sample(input imu_sample_t s);
    imu_result_t r;
    while (!steady && $urandom_range(99) < IDLE_PERCENT) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {s.rate_z, s.rate_y, s.rate_x, s.accel_z, s.accel_y, s.accel_x, s.stamp};
    in_tlast <= s.last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_result(s, r);
    results_due.insert(results_due.size(), r);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == REG_ACCEL_LIMIT) lim_accel = value;
    else if (idx == REG_RATE_LIMIT) lim_rate = value;
    @(posedge clk);
  endtask

  // Registers may only change once every outstanding result has come back.
  task automatic drain_results();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (results_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic imu_sample_t mk_sample(input logic [31:0] stamp,
                                            input int ax, ay, az, rx, ry, rz,
                                            input logic last);
    imu_sample_t s;
    s.stamp = stamp;
    s.accel_x = 16'(ax);
    s.accel_y = 16'(ay);
    s.accel_z = 16'(az);
    s.rate_x = 16'(rx);
    s.rate_y = 16'(ry);
    s.rate_z = 16'(rz);
    s.last = last;
    return s;
  endfunction

  // Axis span scaled to the limit so that magnitudes land on both sides of it.
  function automatic logic [15:0] random_axis(input logic [15:0] limit);
    int span;
    int roll;
    roll = $urandom_range(99);
    span = (int'(limit) * 4) / 5 + 8;
    if (span > 32767) span = 32767;
    if (roll < 12) return 16'($urandom);
    if (roll < 20) begin
      case ($urandom_range(4))
        0: return 16'h8000;
        1: return 16'h7FFF;
        2: return 16'hFFFF;
        3: return 16'h0001;
        default: return 16'h0000;
      endcase
    end
    return 16'(int'($urandom_range(2 * span)) - span);
  endfunction

  function automatic imu_sample_t random_sample(input logic last, input logic rejected);
    imu_sample_t s;
    s.stamp = $urandom;
    s.last = last;
    s.accel_x = random_axis(lim_accel);
    s.accel_y = random_axis(lim_accel);
    s.accel_z = random_axis(lim_accel);
    s.rate_x = random_axis(lim_rate);
    s.rate_y = random_axis(lim_rate);
    s.rate_z = random_axis(lim_rate);
    if (rejected) begin
      s.accel_x = 16'h8000;
      s.rate_y = 16'h7FFF;
    end
    return s;
  endfunction

  task automatic run_batches(input int items);
    int   sent;
    int   len;
    logic rejected;
    sent = 0;
    while (sent < items) begin
      len = ($urandom_range(99) < 10) ? $urandom_range(20, 60) : $urandom_range(1, 12);
      rejected = ($urandom_range(99) < 8);
      for (int i = 0; i < len; i++) send_sample(random_sample(i == len - 1, rejected));
      sent += len;
    end
  endtask

  task automatic test_threshold_edges();
    send_sample(mk_sample(32'h0, 0, 0, 0, 0, 0, 0, 1'b0));
    send_sample(mk_sample(32'hFFFFFFFF, -32768, -32768, -32768, -32768, -32768, -32768, 1'b0));
    send_sample(mk_sample(32'h1, 32767, 32767, 32767, 32767, 32767, 32767, 1'b0));
    send_sample(mk_sample(32'h2, 7679, 0, 0, 0, 0, 0, 1'b0));
    send_sample(mk_sample(32'h3, 0, 7680, 0, 0, 0, 0, 1'b0));
    send_sample(mk_sample(32'h4, 0, 0, -7679, 14335, 0, 0, 1'b0));
    send_sample(mk_sample(32'h5, 0, 0, 0, 0, -14336, 0, 1'b0));
    // The last sample is accepted and joins the batch before the report.
    send_sample(mk_sample(32'h6, 3000, -4000, 5000, 8000, -8000, 5000, 1'b1));
  endtask

  task automatic test_batch_reports();
    // Empty batches, both right after a report and after rejected samples.
    send_sample(mk_sample(32'h10, -32768, 0, 0, 0, 0, 0, 1'b1));
    send_sample(mk_sample(32'h11, 0, 0, 0, 0, 0, 32767, 1'b1));
    // A single accepted sample sets both the minimum and the maximum.
    send_sample(mk_sample(32'h12, 100, 200, 300, -400, 500, -600, 1'b1));
    send_sample(mk_sample(32'h13, 1000, 0, 0, 0, 2000, 0, 1'b0));
    send_sample(mk_sample(32'h14, -5, 3, 0, 7, 0, -9, 1'b0));
    send_sample(mk_sample(32'h15, 4000, 4000, 4000, 8000, 0, 8000, 1'b0));
    send_sample(mk_sample(32'h16, 0, -2500, 100, 0, 0, 1, 1'b1));
    // An accepted sample followed by a rejected last one.
    send_sample(mk_sample(32'h17, 1234, -4321, 77, 300, 300, 300, 1'b0));
    send_sample(mk_sample(32'h18, 20000, 0, 0, 0, 0, 0, 1'b1));
  endtask

  task automatic test_register_writes();
    drain_results();
    write_reg(REG_ACCEL_LIMIT, 16'h0000);
    send_sample(mk_sample(32'h20, 0, 0, 0, 0, 0, 0, 1'b1));
    drain_results();
    write_reg(REG_ACCEL_LIMIT, 16'hFFFF);
    write_reg(REG_RATE_LIMIT, 16'h0000);
    send_sample(mk_sample(32'h21, 0, 0, 0, 0, 0, 0, 1'b1));
    drain_results();
    // Writes to indexes past the register list leave both limits alone.
    write_reg(CFG_IDX_W'(2), 16'hFFFF);
    write_reg(CFG_IDX_W'(8'hFF), 16'hFFFF);
    write_reg(CFG_IDX_W'(8'hAA), 16'hFFFF);
    write_reg(CFG_IDX_W'(8'h55), 16'h0000);
    send_sample(mk_sample(32'h22, 0, 0, 0, 0, 0, 0, 1'b1));
    drain_results();
    write_reg(REG_RATE_LIMIT, 16'hFFFF);
    send_sample(mk_sample(32'h23, -32768, -32768, -32768, -32768, -32768, -32768, 1'b0));
    send_sample(mk_sample(32'h24, 32767, 32767, 32767, 32767, 32767, 32767, 1'b1));
    drain_results();
    write_reg(REG_ACCEL_LIMIT, 16'hA5A5);
    write_reg(REG_RATE_LIMIT, 16'h5A5A);
    send_sample(random_sample(1'b0, 1'b0));
    send_sample(random_sample(1'b0, 1'b0));
    send_sample(random_sample(1'b1, 1'b0));
  endtask

  task automatic test_random_batches();
    drain_results();
    write_reg(REG_ACCEL_LIMIT, ACCEL_LIMIT_RST);
    write_reg(REG_RATE_LIMIT, RATE_LIMIT_RST);
    run_batches(300);
    drain_results();
    write_reg(REG_ACCEL_LIMIT, 16'hFFFF);
    write_reg(REG_RATE_LIMIT, 16'hFFFF);
    run_batches(250);
    drain_results();
    write_reg(REG_ACCEL_LIMIT, 16'($urandom_range(256, 20000)));
    write_reg(REG_RATE_LIMIT, 16'($urandom_range(512, 40000)));
    run_batches(300);
    drain_results();
    write_reg(REG_ACCEL_LIMIT, 16'd300);
    write_reg(REG_RATE_LIMIT, 16'd500);
    run_batches(250);
    drain_results();
    write_reg(REG_ACCEL_LIMIT, 16'h0000);
    write_reg(REG_RATE_LIMIT, 16'($urandom));
    run_batches(60);
  endtask

  task automatic test_steady_stream();
    drain_results();
    write_reg(REG_ACCEL_LIMIT, 16'($urandom_range(4000, 12000)));
    write_reg(REG_RATE_LIMIT, 16'($urandom_range(8000, 24000)));
    steady <= 1'b1;
    run_batches(150);
    steady <= 1'b0;
  endtask

  // The sink holds off while the source keeps offering, so the block backs up.
  task automatic test_output_stall();
    drain_results();
    steady <= 1'b1;
    fork
      begin
        sink_hold <= 1'b1;
        repeat (STALL_CYCLES) @(posedge clk);
        sink_hold <= 1'b0;
      end
      run_batches(40);
    join
    steady <= 1'b0;
  endtask

  task automatic check_field(input string name, input logic [31:0] want, got);
    if (got !== want) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      err_count++;
    end
  endtask

  task automatic check_result();
    imu_result_t want;
    if (results_due.size() == 0) begin
      $error("output beat with no sample outstanding, time_out %0h", out_tdata[31:0]);
      err_count++;
    end else begin
      want = results_due.pop_front();
      check_field("time_out", want.time_out, out_tdata[31:0]);
      check_field("accel_magnitude", want.accel_mag, out_tdata[47:32]);
      check_field("rate_magnitude", want.rate_mag, out_tdata[63:48]);
      check_field("accel_min", want.accel_min, out_tdata[79:64]);
      check_field("accel_max", want.accel_max, out_tdata[95:80]);
      check_field("accel_mean", want.accel_mean, out_tdata[111:96]);
      check_field("rate_min", want.rate_min, out_tdata[127:112]);
      check_field("rate_max", want.rate_max, out_tdata[143:128]);
      check_field("rate_mean", want.rate_mean, out_tdata[159:144]);
      check_field("stats_ready", want.stats_ready, out_tlast);
      check_field("accepted", want.accepted, out_tuser[0]);
      check_field("no_samples", want.no_samples, out_tuser[1]);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) check_result();
    if (sink_hold) out_tready <= 1'b0;
    else if (steady) out_tready <= 1'b1;
    else out_tready <= ($urandom_range(99) >= IDLE_PERCENT);
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_threshold_edges();
    test_batch_reports();
    test_register_writes();
    test_random_batches();
    test_steady_stream();
    test_output_stall();
    drain_results();
    repeat (64) @(posedge clk);
    if (err_count == 0 && results_due.size() == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule

/* imu_magnitude_statistics.f */
sv/ims_pkg.sv
sv/ims_ctrl.sv
sv/ims_datapath.sv
sv/imu_magnitude_statistics.sv
sim/imu_magnitude_statistics_tb.sv
